/* rtl/spg_pkg.sv */
// spg_pkg: shared widths, codes and types for the step pulse generator
// used by every module under rtl/, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package spg_pkg;

    localparam int TIMEBASE_BITS    = 16;
    localparam int FREQ_BITS        = 16;
    localparam int SPR_BITS         = 12;
    localparam int POSITION_BITS    = 12;
    localparam int DIR_SEL_BITS     = 2;
    localparam int COUNTER_BITS_DEF = 16;
    localparam int MAX_COUNTER_BITS = 32;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = 16;

    localparam logic [TIMEBASE_BITS-1:0] TIMEBASE_RESET = 16'd10000;
    localparam logic [SPR_BITS-1:0]      SPR_RESET      = 12'd3200;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_TIMEBASE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_SPR      = 2'd1;

    // input codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_SPEED = 1'b1;
    localparam logic [DIR_SEL_BITS-1:0] DIRECTION_CW  = 2'd0;
    localparam logic [DIR_SEL_BITS-1:0] DIRECTION_ACW = 2'd1;

    // direction pin levels
    localparam logic DIR_LEVEL_CW  = 1'b0;
    localparam logic DIR_LEVEL_ACW = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SET,
        OP_STOP
    } t_op;

    typedef enum logic [1:0] {
        DIR_CMD_CW,
        DIR_CMD_ACW,
        DIR_CMD_KEEP
    } t_dir_cmd;

    typedef struct packed {
        t_op                  op;
        logic [FREQ_BITS-1:0] freq;
        t_dir_cmd             dir;
    } t_item;

    typedef struct packed {
        logic                     start;
        logic [TIMEBASE_BITS-1:0] dividend;
        logic [TIMEBASE_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic [TIMEBASE_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

/* rtl/step_pulse_generator_with_position.sv */
// Step/direction pulse generator: tick and stop requests sustain one request per cycle while
// the output is ready and no division runs; a set-speed request with nonzero frequency
// holds the back end in the serial divider (one quotient bit per cycle).
// A two-entry queue lets the front keep accepting while the back end divides or stalls.
// Synchronous active-low reset clears state and registers timebase to 10000, steps to 3200.
`timescale 1ns / 1ps
`default_nettype none

module step_pulse_generator_with_position
    import spg_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_cmd,
    input  wire logic [FREQ_BITS-1:0]      i_freq,
    input  wire logic [DIR_SEL_BITS-1:0]   i_direction,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_pulse_level,
    output logic                           o_dir_level,
    output logic [POSITION_BITS-1:0]       o_position,
    output logic                           o_update_event,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic [TIMEBASE_BITS-1:0] r_timebase;
    logic [SPR_BITS-1:0]      r_steps_per_rev;
    logic                     w_head_valid;
    t_item                    w_head;
    logic                     w_pop;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timebase      <= TIMEBASE_RESET;
            r_steps_per_rev <= SPR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_TIMEBASE: r_timebase      <= i_cfg_data[TIMEBASE_BITS-1:0];
                CFG_IDX_SPR:      r_steps_per_rev <= i_cfg_data[SPR_BITS-1:0];
                default: begin
                    r_timebase <= r_timebase;
                end
            endcase
        end
    end

    spg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_freq       (i_freq),
        .i_direction  (i_direction),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    spg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    spg_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_timebase      (r_timebase),
        .i_steps_per_rev (r_steps_per_rev),
        .o_div_req       (w_div_req),
        .i_div_rsp       (w_div_rsp),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pulse_level   (o_pulse_level),
        .o_dir_level     (o_dir_level),
        .o_position      (o_position),
        .o_update_event  (o_update_event)
    );

endmodule

`default_nettype wire

/* rtl/spg_front.sv */
// spg_front: accepts requests, classifies them and queues them for the back end
// depends on spg_pkg
`timescale 1ns / 1ps
`default_nettype none

module spg_front
    import spg_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_cmd,
    input  wire logic [FREQ_BITS-1:0]    i_freq,
    input  wire logic [DIR_SEL_BITS-1:0] i_direction,
    output logic                         o_head_valid,
    output t_item                        o_head,
    input  wire logic                    i_pop
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_item                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]  r_count, n_count;
    t_item                w_item;
    logic                 w_push;
    logic                 w_pop;

    always_comb begin
        w_item.freq = i_freq;
        if (i_cmd == CMD_SPEED) begin
            w_item.op = (i_freq != '0) ? OP_SET : OP_STOP;
        end else begin
            w_item.op = OP_TICK;
        end
        unique case (i_direction)
            DIRECTION_CW:  w_item.dir = DIR_CMD_CW;
            DIRECTION_ACW: w_item.dir = DIR_CMD_ACW;
            default:       w_item.dir = DIR_CMD_KEEP;
        endcase
    end

    assign o_in_ready   = (r_count < CNT_BITS'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_push       = i_in_valid && o_in_ready;
    assign w_pop        = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/spg_div.sv */
// spg_div: restoring divider for timebase / freq, one quotient bit per cycle
// depends on spg_pkg
`timescale 1ns / 1ps
`default_nettype none

module spg_div
    import spg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int BITS     = TIMEBASE_BITS;
    localparam int CNT_BITS = $clog2(BITS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [BITS-1:0]     r_rem, n_rem;
    logic [BITS-1:0]     r_quo, n_quo;
    logic [BITS-1:0]     r_divisor;
    logic [BITS:0]       w_rem_shift;
    logic [BITS:0]       w_rem_sub;
    logic                w_fits;

    always_comb begin
        w_rem_shift = {r_rem, r_quo[BITS-1]};
        w_rem_sub   = w_rem_shift - {1'b0, r_divisor};
        w_fits      = !w_rem_sub[BITS];
        n_rem       = w_fits ? w_rem_sub[BITS-1:0] : w_rem_shift[BITS-1:0];
        n_quo       = {r_quo[BITS-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
            r_rem     <= '0;
            r_quo     <= '0;
            r_divisor <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cnt     <= CNT_BITS'(BITS - 1);
                r_rem     <= '0;
                r_quo     <= i_req.dividend;
                r_divisor <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

/* rtl/spg_back.sv */
// spg_back: tick counter, speed setup, position counter and result register
// depends on spg_pkg, drives spg_div through a request struct
`timescale 1ns / 1ps
`default_nettype none

module spg_back
    import spg_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_head_valid,
    input  wire t_item                    i_head,
    output logic                          o_pop,
    input  wire logic [TIMEBASE_BITS-1:0] i_timebase,
    input  wire logic [SPR_BITS-1:0]      i_steps_per_rev,
    output t_div_req                      o_div_req,
    input  wire t_div_rsp                 i_div_rsp,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic                          o_pulse_level,
    output logic                          o_dir_level,
    output logic [POSITION_BITS-1:0]      o_position,
    output logic                          o_update_event
);

    typedef enum logic {
        S_RUN,
        S_DIV
    } t_state;

    t_state                    r_state, n_state;
    logic [COUNTER_BITS-1:0]   r_tick_count, n_tick_count;
    logic [COUNTER_BITS-1:0]   r_period, n_period;
    logic [COUNTER_BITS-1:0]   r_compare, n_compare;
    logic                      r_running, n_running;
    logic                      r_dir, n_dir;
    logic [POSITION_BITS-1:0]  r_position, n_position;
    logic                      r_out_valid, n_out_valid;
    logic                      r_pulse, n_pulse;
    logic                      r_event, n_event;

    logic                      w_out_free;
    logic                      w_take;
    logic [POSITION_BITS:0]    w_pos_inc;
    logic [POSITION_BITS-1:0]  w_pos_dec;
    logic [POSITION_BITS-1:0]  w_pos_step;
    logic [TIMEBASE_BITS-1:0]  w_period_q;
    logic [MAX_COUNTER_BITS-1:0] w_period_ext;
    logic                      w_dir_new;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_take     = (r_state == S_RUN) && i_head_valid && w_out_free;
    assign o_pop      = w_take;

    // position steps with wrap inside 0..steps_per_rev
    always_comb begin
        w_pos_inc = {1'b0, r_position} + 1'b1;
        w_pos_dec = r_position - 1'b1;
        if (r_dir == DIR_LEVEL_CW) begin
            w_pos_step = (w_pos_inc > {1'b0, i_steps_per_rev}) ? '0
                                                              : w_pos_inc[POSITION_BITS-1:0];
        end else if (r_position == '0) begin
            w_pos_step = i_steps_per_rev;
        end else begin
            w_pos_step = (w_pos_dec > i_steps_per_rev) ? '0 : w_pos_dec;
        end
    end

    // period from quotient, a zero quotient gives a period of one
    always_comb begin
        w_period_q   = (i_div_rsp.quotient == '0) ? TIMEBASE_BITS'(1)
                                                  : i_div_rsp.quotient - 1'b1;
        w_period_ext = MAX_COUNTER_BITS'(w_period_q);
    end

    always_comb begin
        unique case (i_head.dir)
            DIR_CMD_CW:  w_dir_new = DIR_LEVEL_CW;
            DIR_CMD_ACW: w_dir_new = DIR_LEVEL_ACW;
            default:     w_dir_new = r_dir;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_tick_count = r_tick_count;
        n_period     = r_period;
        n_compare    = r_compare;
        n_running    = r_running;
        n_dir        = r_dir;
        n_position   = r_position;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_pulse      = r_pulse;
        n_event      = r_event;

        o_div_req.start    = 1'b0;
        o_div_req.dividend = i_timebase;
        o_div_req.divisor  = i_head.freq;

        unique case (r_state)
            S_RUN: begin
                if (w_take) begin
                    unique case (i_head.op)
                        OP_TICK: begin
                            if (r_tick_count == r_period) begin
                                n_tick_count = '0;
                                n_event      = 1'b1;
                                // compare nonzero implies period / compare >= 2
                                if (r_running && (r_compare != '0)) begin
                                    n_position = w_pos_step;
                                end
                            end else begin
                                n_tick_count = r_tick_count + 1'b1;
                                n_event      = 1'b0;
                            end
                            n_pulse     = (n_tick_count < r_compare);
                            n_out_valid = 1'b1;
                        end
                        OP_STOP: begin
                            n_compare   = '0;
                            n_running   = 1'b0;
                            n_dir       = w_dir_new;
                            n_pulse     = 1'b0;
                            n_event     = 1'b0;
                            n_out_valid = 1'b1;
                        end
                        OP_SET: begin
                            n_dir           = w_dir_new;
                            o_div_req.start = 1'b1;
                            n_state         = S_DIV;
                        end
                        default: begin
                            n_state = S_RUN;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_period    = w_period_ext[COUNTER_BITS-1:0];
                    n_compare   = n_period >> 1;
                    n_running   = 1'b1;
                    n_pulse     = (r_tick_count < n_compare);
                    n_event     = 1'b0;
                    n_out_valid = 1'b1;
                    n_state     = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_tick_count <= '0;
            r_period     <= '0;
            r_compare    <= '0;
            r_running    <= 1'b0;
            r_dir        <= DIR_LEVEL_CW;
            r_position   <= '0;
            r_out_valid  <= 1'b0;
            r_pulse      <= 1'b0;
            r_event      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tick_count <= n_tick_count;
            r_period     <= n_period;
            r_compare    <= n_compare;
            r_running    <= n_running;
            r_dir        <= n_dir;
            r_position   <= n_position;
            r_out_valid  <= n_out_valid;
            r_pulse      <= n_pulse;
            r_event      <= n_event;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pulse_level  = r_pulse;
    assign o_dir_level    = r_dir;
    assign o_position     = r_position;
    assign o_update_event = r_event;

endmodule

`default_nettype wire
